/* rtl/core/assert_macros.svh */
// assertion macros shared by the motion intensity tracker rtl
// expects clk and rst in the scope where the macros are used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold on every clock edge out of reset
`define MIT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// condition that must never be true out of reset
`define MIT_NEVER(lbl, expr, msg) \
  `MIT_ASSERT(lbl, !(expr), msg)

`endif

/* rtl/core/mit_pkg.sv */
// shared types, constants and saturation helpers for the motion intensity tracker
// no dependencies
package mit_pkg;

  localparam int WINDOW_DEPTH_DEF = 10;
  localparam int SAMPLE_WIDTH_DEF = 16;

  localparam logic [15:0] PERIOD_SAMPLES_RST  = 16'd52;
  localparam logic [31:0] MOVEMENT_THRESH_RST = 32'd819;
  localparam logic [15:0] TIMEOUT_PERIODS_RST = 16'd30;

  // q2.30 coefficients
  localparam logic signed [31:0] HP_INV_GAIN = 32'sd1042248399;
  localparam logic signed [31:0] HP_POLE     = 32'sd1010754974;
  localparam logic signed [31:0] LP_INV_GAIN = 32'sd466092;
  localparam logic signed [31:0] LP_C_OLD    = -32'sd1011406104;
  localparam logic signed [31:0] LP_C_NEW    = 32'sd2083283562;

  localparam int V_W   = 51;
  localparam int RES_W = 52;
  localparam int SUM_W = 54;

  typedef enum logic [1:0] {
    CFG_PERIOD  = 2'd0,
    CFG_THRESH  = 2'd1,
    CFG_TIMEOUT = 2'd2
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_HPX,
    ST_HPH,
    ST_SQ,
    ST_LPX,
    ST_LP0,
    ST_LP1,
    ST_PEAK,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic                    start;
    logic                    raw;
    logic signed [V_W-1:0]   v;
    logic signed [31:0]      c;
  } mul_req_t;

  typedef struct packed {
    logic                    done;
    logic signed [RES_W-1:0] res;
  } mul_rsp_t;

  function automatic logic signed [23:0] sat24(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    hi = SUM_W'(24'sh7fffff);
    lo = -hi - SUM_W'(1);
    if (v > hi) return 24'sh7fffff;
    else if (v < lo) return 24'sh800000;
    else return v[23:0];
  endfunction

  function automatic logic signed [39:0] sat40(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    hi = SUM_W'(40'sh7fffffffff);
    lo = -hi - SUM_W'(1);
    if (v > hi) return 40'sh7fffffffff;
    else if (v < lo) return 40'sh8000000000;
    else return v[39:0];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    hi = SUM_W'(32'sh7fffffff);
    lo = -hi - SUM_W'(1);
    if (v > hi) return 32'sh7fffffff;
    else if (v < lo) return 32'sh80000000;
    else return v[31:0];
  endfunction

endpackage

/* rtl/core/mit_mulq.sv */
// shared multiplier unit: q2.30 rounded product or raw product, taken in only while idle
// depends on mit_pkg
module mit_mulq (
  input  logic               clk,
  input  logic               rst,
  input  mit_pkg::mul_req_t  req,
  output mit_pkg::mul_rsp_t  rsp
);
  import mit_pkg::*;

  localparam int A_W   = V_W - 16;
  localparam int P_W   = A_W + 32;
  localparam int ACC_W = P_W + 16;

  typedef enum logic [1:0] {PH_IDLE, PH_LO, PH_SUM} ph_t;

  ph_t                     ph;
  logic [15:0]             lo_r;
  logic signed [31:0]      c_r;
  logic                    raw_r;
  logic signed [P_W-1:0]   prod;
  logic signed [ACC_W-1:0] acc;
  logic signed [A_W-1:0]   mul_a;
  logic signed [31:0]      mul_b;
  logic signed [P_W-1:0]   prod_next;
  logic signed [ACC_W-1:0] sum;
  logic signed [ACC_W-1:0] rnd;

  assign mul_a     = (ph == PH_IDLE) ? A_W'(req.v >>> 16) : {{(A_W-16){1'b0}}, lo_r};
  assign mul_b     = (ph == PH_IDLE) ? req.c : c_r;
  assign prod_next = mul_a * mul_b;
  assign sum       = acc + ACC_W'(prod);
  assign rnd       = sum >>> 30;

  always_ff @(posedge clk) begin
    if (rst) begin
      ph       <= PH_IDLE;
      rsp.done <= 1'b0;
    end else begin
      rsp.done <= 1'b0;
      unique case (ph)
        PH_IDLE: begin
          if (req.start) begin
            prod  <= prod_next;
            lo_r  <= req.v[15:0];
            c_r   <= req.c;
            raw_r <= req.raw;
            ph    <= PH_LO;
          end
        end
        PH_LO: begin
          acc  <= (ACC_W'(prod) <<< 16) + (raw_r ? ACC_W'(0) : (ACC_W'(1) <<< 29));
          prod <= prod_next;
          ph   <= PH_SUM;
        end
        PH_SUM: begin
          rsp.res  <= raw_r ? sum[RES_W-1:0] : rnd[RES_W-1:0];
          rsp.done <= 1'b1;
          ph       <= PH_IDLE;
        end
        default: ph <= PH_IDLE;
      endcase
    end
  end

endmodule

/* rtl/core/mit_window.sv */
// peak window: shift line of period results and a rotating max scan
// depends on mit_pkg
module mit_window #(
  parameter int DEPTH = mit_pkg::WINDOW_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  logic signed [31:0] din,
  output logic               busy,
  output logic [30:0]        peak
);
  import mit_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);

  logic signed [31:0] win [DEPTH];
  logic signed [31:0] mx;
  logic [CW-1:0]      cnt;

  assign busy = (cnt != '0);
  assign peak = mx[30:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DEPTH; i++) win[i] <= '0;
      cnt <= '0;
    end else if (push) begin
      for (int i = 0; i < DEPTH - 1; i++) win[i] <= win[i+1];
      win[DEPTH-1] <= din;
      cnt <= CW'(DEPTH);
      mx  <= '0;
    end else if (busy) begin
      if (win[0] > mx) mx <= win[0];
      for (int i = 0; i < DEPTH - 1; i++) win[i] <= win[i+1];
      win[DEPTH-1] <= win[0];
      cnt <= cnt - CW'(1);
    end
  end

endmodule

/* rtl/core/motion_intensity_tracker_core.sv */
// Each accelerometer sample takes twelve multiply operations on the one shared
// multiplier; a sample that ends a period then goes through the peak window
// scan and the output load. The input is ready only in the idle state; the output
// register holds one result while the next sample is taken in.
// depends on mit_pkg, mit_mulq, mit_window and assert_macros.svh
`include "assert_macros.svh"
module motion_intensity_tracker_core #(
  parameter int WINDOW_DEPTH = mit_pkg::WINDOW_DEPTH_DEF,
  parameter int SAMPLE_WIDTH = mit_pkg::SAMPLE_WIDTH_DEF,
  localparam int IN_W = ((3 * SAMPLE_WIDTH + 7) / 8) * 8
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_tvalid,
  output logic            s_tready,
  input  logic [IN_W-1:0] s_tdata,   // accel_x, accel_y, accel_z, zero pad
  output logic            m_tvalid,
  input  logic            m_tready,
  output logic [95:0]     m_tdata,   // period_count, smoothed_intensity, window_peak, stop_request
  input  logic            cfg_we,
  input  logic [1:0]      cfg_index,
  input  logic [31:0]     cfg_data
);
  import mit_pkg::*;

  localparam int SW = SAMPLE_WIDTH;

  state_t state, state_next;
  mul_req_t mul_req;
  mul_rsp_t mul_rsp;
  logic win_push, win_busy;
  logic [30:0] win_peak;

  logic [15:0] period_samples;
  logic [31:0] movement_threshold;
  logic [15:0] timeout_periods;

  // y and z axes held while x is in the multiplier
  logic signed [SW-1:0] samp [2];
  logic [1:0]           ax;
  logic signed [23:0]   hp_in_prev [3];
  logic signed [23:0]   hp_out_prev [3];
  logic signed [23:0]   xcur;
  logic [47:0]          energy;
  logic signed [39:0]   lxcur;
  logic signed [40:0]   t0;
  logic signed [39:0]   lp_in_hist [2];
  logic signed [39:0]   lp_out_hist [2];
  logic [15:0]          sample_count;
  logic [31:0]          period_counter;
  logic [31:0]          last_movement_period;
  logic signed [31:0]   smooth;

  logic [31:0]          out_count;
  logic signed [31:0]   out_smooth;
  logic [30:0]          out_peak;
  logic                 out_stop;

  logic in_xfer, emit_load, period_end, movement, mul_wait;
  logic signed [SW-1:0]    next_samp;
  logic signed [SUM_W-1:0] h_sum, xs, y_sum, sm_sum;
  logic signed [23:0]      h_new;
  logic [47:0]             energy_next;
  logic signed [39:0]      lx_new, y_new;
  logic signed [31:0]      smooth_new;
  logic [31:0]             pc_new;
  logic                    stop_new;

  mit_mulq u_mulq (
    .clk (clk),
    .rst (rst),
    .req (mul_req),
    .rsp (mul_rsp)
  );

  mit_window #(.DEPTH(WINDOW_DEPTH)) u_window (
    .clk  (clk),
    .rst  (rst),
    .push (win_push),
    .din  (smooth_new),
    .busy (win_busy),
    .peak (win_peak)
  );

  assign s_tready  = (state == ST_IDLE);
  assign in_xfer   = s_tvalid && s_tready;
  assign emit_load = (state == ST_EMIT) && (!m_tvalid || m_tready);
  assign m_tdata   = {out_stop, out_peak, out_smooth, out_count};
  assign mul_wait  = (state == ST_IDLE) || (state == ST_PEAK) || (state == ST_EMIT);

  assign next_samp   = (ax == 2'd0) ? samp[0] : samp[1];
  assign h_sum       = SUM_W'(xcur) - SUM_W'(hp_in_prev[ax]) + SUM_W'(mul_rsp.res);
  assign h_new       = sat24(h_sum);
  assign energy_next = energy + mul_rsp.res[47:0];
  assign lx_new      = sat40(SUM_W'(mul_rsp.res));
  assign xs          = SUM_W'(lp_in_hist[0]) + (SUM_W'(lp_in_hist[1]) <<< 1) + SUM_W'(lxcur);
  assign y_sum       = ((xs + SUM_W'(2048)) >>> 12) + SUM_W'(t0) + SUM_W'(mul_rsp.res);
  assign y_new       = sat40(y_sum);
  assign sm_sum      = (SUM_W'(y_new) + SUM_W'(4)) >>> 3;
  assign smooth_new  = sat32(sm_sum);
  assign period_end  = (sample_count >= period_samples);
  assign movement    = ({2'b00, energy} > {4'b0000, movement_threshold, 14'b0});
  assign pc_new      = (period_counter == '1) ? period_counter : period_counter + 32'd1;
  assign stop_new    = ({1'b0, pc_new} >
                        ({1'b0, last_movement_period} + {17'b0, timeout_periods}));
  assign win_push    = (state == ST_LP1) && mul_rsp.done && period_end;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (s_tvalid) state_next = ST_HPX;
      ST_HPX:  if (mul_rsp.done) state_next = ST_HPH;
      ST_HPH:  if (mul_rsp.done) state_next = ST_SQ;
      ST_SQ:   if (mul_rsp.done) state_next = (ax == 2'd2) ? ST_LPX : ST_HPX;
      ST_LPX:  if (mul_rsp.done) state_next = ST_LP0;
      ST_LP0:  if (mul_rsp.done) state_next = ST_LP1;
      ST_LP1:  if (mul_rsp.done) state_next = period_end ? ST_PEAK : ST_IDLE;
      ST_PEAK: if (!win_busy) state_next = ST_EMIT;
      ST_EMIT: if (emit_load) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // multiplier requests
  always_comb begin
    mul_req = '0;
    unique case (state)
      ST_IDLE: begin
        mul_req.start = in_xfer;
        mul_req.v     = V_W'($signed(s_tdata[SW-1:0])) <<< 7;
        mul_req.c     = HP_INV_GAIN;
      end
      ST_HPX: begin
        mul_req.start = mul_rsp.done;
        mul_req.v     = V_W'(hp_out_prev[ax]);
        mul_req.c     = HP_POLE;
      end
      ST_HPH: begin
        mul_req.start = mul_rsp.done;
        mul_req.raw   = 1'b1;
        mul_req.v     = V_W'(h_new);
        mul_req.c     = 32'(h_new);
      end
      ST_SQ: begin
        mul_req.start = mul_rsp.done;
        if (ax == 2'd2) begin
          mul_req.v = $signed({1'b0, energy_next, 2'b00});
          mul_req.c = LP_INV_GAIN;
        end else begin
          mul_req.v = V_W'(next_samp) <<< 7;
          mul_req.c = HP_INV_GAIN;
        end
      end
      ST_LPX: begin
        mul_req.start = mul_rsp.done;
        mul_req.v     = V_W'(lp_out_hist[0]);
        mul_req.c     = LP_C_OLD;
      end
      ST_LP0: begin
        mul_req.start = mul_rsp.done;
        mul_req.v     = V_W'(lp_out_hist[1]);
        mul_req.c     = LP_C_NEW;
      end
      ST_LP1, ST_PEAK, ST_EMIT: mul_req = '0;
      default: mul_req = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state                <= ST_IDLE;
      period_samples       <= PERIOD_SAMPLES_RST;
      movement_threshold   <= MOVEMENT_THRESH_RST;
      timeout_periods      <= TIMEOUT_PERIODS_RST;
      for (int i = 0; i < 3; i++) begin
        hp_in_prev[i]  <= '0;
        hp_out_prev[i] <= '0;
      end
      for (int i = 0; i < 2; i++) begin
        lp_in_hist[i]  <= '0;
        lp_out_hist[i] <= '0;
      end
      sample_count         <= '0;
      period_counter       <= '0;
      last_movement_period <= '0;
      ax                   <= '0;
      m_tvalid             <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_PERIOD:  period_samples     <= cfg_data[15:0];
          CFG_THRESH:  movement_threshold <= cfg_data;
          CFG_TIMEOUT: timeout_periods    <= cfg_data[15:0];
          default: ;
        endcase
      end
      if (in_xfer) begin
        samp[0] <= s_tdata[2*SW-1:SW];
        samp[1] <= s_tdata[3*SW-1:2*SW];
        ax      <= '0;
        energy  <= '0;
      end
      if (mul_rsp.done) begin
        case (state)
          ST_HPX: xcur <= sat24(SUM_W'(mul_rsp.res));
          ST_HPH: begin
            hp_in_prev[ax]  <= xcur;
            hp_out_prev[ax] <= h_new;
          end
          ST_SQ: begin
            energy <= energy_next;
            if (ax != 2'd2) ax <= ax + 2'd1;
          end
          ST_LPX: lxcur <= lx_new;
          ST_LP0: t0 <= mul_rsp.res[40:0];
          ST_LP1: begin
            lp_in_hist[0]  <= lp_in_hist[1];
            lp_in_hist[1]  <= lxcur;
            lp_out_hist[0] <= lp_out_hist[1];
            lp_out_hist[1] <= y_new;
            if (movement) last_movement_period <= period_counter;
            if (period_end) begin
              sample_count <= '0;
              smooth       <= smooth_new;
            end else begin
              sample_count <= sample_count + 16'd1;
            end
          end
          default: ;
        endcase
      end
      if (emit_load) begin
        period_counter <= pc_new;
        out_count      <= pc_new;
        out_smooth     <= smooth;
        out_peak       <= win_peak;
        out_stop       <= stop_new;
        m_tvalid       <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  `MIT_NEVER(a_done_when_waiting, mul_rsp.done && mul_wait, "multiply result while waiting")
  `MIT_ASSERT(a_scan_in_peak, win_busy |-> state == ST_PEAK, "window scan outside peak state")
  `MIT_ASSERT(a_pc_step, !$stable(period_counter) |-> period_counter == $past(pc_new), "count skip")
  `MIT_ASSERT(a_load_from_emit, $rose(m_tvalid) |-> $past(state) == ST_EMIT, "load outside emit")

endmodule
